// ===== design/wpng_pkg.sv =====
// ----------------------------------------------------------------------------
// wpng_pkg
// Shared widths, constants and register codes of the power-keyed noise gate.
// ----------------------------------------------------------------------------
package wpng_pkg;

    localparam int WINDOW_LEN_DEF = 1024;

    localparam int SAMPLE_W   = 16;     // Q1.15 audio sample
    localparam int SQ_W       = 31;     // unsigned Q1.30 squared sample
    localparam int GAIN_W     = 25;     // Q1.24 gain and steps
    localparam int GAIN_FRAC  = 24;
    localparam int CFG_DATA_W = 31;
    localparam int CFG_IDX_W  = 2;

    localparam logic [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) << GAIN_FRAC;

    // register reset values
    localparam logic [SQ_W-1:0]   PWR_THR_RST = SQ_W'(10737418);
    localparam logic [GAIN_W-1:0] STEP_RST    = GAIN_W'(699);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GATE_ENABLE     = 2'd0,
        CFG_POWER_THRESHOLD = 2'd1,
        CFG_ATTACK_STEP     = 2'd2,
        CFG_RELEASE_STEP    = 2'd3
    } t_cfg_idx;

endpackage

// ===== design/wpng_if.sv =====
// ----------------------------------------------------------------------------
// wpng_if
// Valid/ready channels of the noise gate: sample in, result out, config write.
// ----------------------------------------------------------------------------
interface wpng_in_if import wpng_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink   (input valid, input sample_in, output ready);
endinterface

interface wpng_out_if import wpng_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       gate_is_open;

    modport source (output valid, output sample_out, output gate_is_open, input ready);
    modport sink   (input valid, input sample_out, input gate_is_open, output ready);
endinterface

interface wpng_cfg_if import wpng_pkg::*; ();
    logic                  valid;
    logic                  ready;
    t_cfg_idx              index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/windowed_power_noise_gate.sv =====
// ----------------------------------------------------------------------------
// windowed_power_noise_gate
// Noise gate keyed by the moving-average power of the last WINDOW_LEN samples.
// ----------------------------------------------------------------------------
// Channels: i_in carries one Q1.15 sample per beat, o_out one gated sample
// and the gate flag per beat, i_cfg writes the four registers (always ready).
// Write the registers only while no sample is in flight.
// Throughput: one sample per cycle while o_out takes its beats, through
// the four-stage pipe (ring read, window sum, gain and flag update,
// output multiply).
// The mean-power compare is done against threshold * WINDOW_LEN, scaled
// once at the config write, so no divider sits in the sample path.
// Reset: gate open, gain zero, window sum zero; ring entries not yet written
// since reset read as zero through a wrap flag, so there is no clearing pass
// and a sample is taken in the first cycle after reset.
// Stall: while o_out holds a beat that is not taken, the whole pipe holds
// and i_in.ready drops in the same cycle.
// ----------------------------------------------------------------------------
module windowed_power_noise_gate import wpng_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    wpng_cfg_if.sink          i_cfg,
    wpng_in_if.sink           i_in,
    wpng_out_if.source        o_out
);

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int SUM_W = POS_W + SQ_W;
    localparam int THR_W = SUM_W + 1;
    localparam logic [THR_W-1:0] WIN_EXT    = THR_W'(WINDOW_LEN);
    localparam logic [THR_W-1:0] THR_LO_RST = THR_W'(PWR_THR_RST) * WIN_EXT;

    // configuration
    logic              r_en;
    logic [THR_W-1:0]  r_thr_lo;
    logic [THR_W-1:0]  r_thr_hi;
    logic [GAIN_W-1:0] r_attack;
    logic [GAIN_W-1:0] r_release;
    logic [THR_W-1:0]  n_thr_lo;

    // pipeline
    logic                       adv;
    logic                       accept;
    logic                       r_a_valid, r_a_en;
    logic signed [SAMPLE_W-1:0] r_a_sample;
    logic                       r_b_valid, r_b_en;
    logic signed [SAMPLE_W-1:0] r_b_sample;
    logic                       r_c_valid, r_c_en;
    logic signed [SAMPLE_W-1:0] r_c_sample;
    logic                       r_d_valid;
    logic signed [SAMPLE_W-1:0] r_d_sample;
    logic                       r_d_open;

    // gate state
    logic              r_open;
    logic [GAIN_W-1:0] r_gain;
    logic              n_open;
    logic [GAIN_W-1:0] n_gain;

    logic [SUM_W-1:0]               sum;
    logic [GAIN_W:0]                gain_up;
    logic [GAIN_W-1:0]              gain_dn;
    logic                           below;
    logic                           above;
    logic signed [SAMPLE_W+GAIN_W:0] prod;

    assign adv    = !r_d_valid || o_out.ready;
    assign accept = i_in.valid && adv;

    assign i_in.ready  = adv;
    assign i_cfg.ready = 1'b1;

    wpng_power #(
        .WINDOW_LEN (WINDOW_LEN)
    ) u_power (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept && r_en),
        .i_sample (i_in.sample_in),
        .i_adv    (adv && r_a_valid && r_a_en),
        .o_sum    (sum)
    );

    // ---- configuration ----
    assign n_thr_lo = THR_W'(i_cfg.data) * WIN_EXT;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en      <= 1'b0;
            r_thr_lo  <= THR_LO_RST;
            r_thr_hi  <= THR_LO_RST + WIN_EXT;
            r_attack  <= STEP_RST;
            r_release <= STEP_RST;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_GATE_ENABLE: begin
                    r_en <= i_cfg.data[0];
                end
                CFG_POWER_THRESHOLD: begin
                    r_thr_lo <= n_thr_lo;
                    r_thr_hi <= n_thr_lo + WIN_EXT;
                end
                CFG_ATTACK_STEP: begin
                    r_attack <= i_cfg.data[GAIN_W-1:0];
                end
                CFG_RELEASE_STEP: begin
                    r_release <= i_cfg.data[GAIN_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ---- gain and flag update ----
    // floor(sum / N) < T  <=>  sum < T*N ;  floor(sum / N) > T  <=>  sum >= (T+1)*N
    assign below = THR_W'(sum) < r_thr_lo;
    assign above = THR_W'(sum) >= r_thr_hi;

    assign gain_up = {1'b0, r_gain} + {1'b0, r_attack};
    assign gain_dn = (r_release > r_gain) ? '0 : r_gain - r_release;

    always_comb begin
        if (r_open) begin
            n_gain = (gain_up > {1'b0, GAIN_ONE}) ? GAIN_ONE : gain_up[GAIN_W-1:0];
            n_open = !below;
        end else begin
            n_gain = (gain_dn > GAIN_ONE) ? GAIN_ONE : gain_dn;
            n_open = above;
        end
    end

    // ---- output multiply: arithmetic bits above the fraction give the floor ----
    assign prod = r_c_sample * signed'({1'b0, r_gain});

    // ---- pipeline control ----
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_open    <= 1'b1;
            r_gain    <= '0;
        end else if (adv) begin
            r_a_valid <= i_in.valid;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            if (r_b_valid && r_b_en) begin
                r_open <= n_open;
                r_gain <= n_gain;
            end
        end
    end

    // ---- pipeline payload ----
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_en     <= r_en;
            r_a_sample <= i_in.sample_in;
            r_b_en     <= r_a_en;
            r_b_sample <= r_a_sample;
            r_c_en     <= r_b_en;
            r_c_sample <= r_b_sample;
            r_d_open   <= r_open;
            r_d_sample <= r_c_en ? prod[GAIN_FRAC+SAMPLE_W-1:GAIN_FRAC] : r_c_sample;
        end
    end

    assign o_out.valid        = r_d_valid;
    assign o_out.sample_out   = r_d_sample;
    assign o_out.gate_is_open = r_d_open;

endmodule

// ===== design/wpng_power.sv =====
// ----------------------------------------------------------------------------
// wpng_power
// Ring of squared samples with a running window sum. One push per cycle;
// the evicted square is registered at the push and subtracted on i_adv.
// ----------------------------------------------------------------------------
module wpng_power import wpng_pkg::*; #(
    parameter int WINDOW_LEN = WINDOW_LEN_DEF,
    localparam int POS_W     = $clog2(WINDOW_LEN),
    localparam int SUM_W     = POS_W + SQ_W
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic                       i_adv,
    output logic [SUM_W-1:0]           o_sum
);

    logic [SQ_W-1:0] r_ring [WINDOW_LEN];

    logic [POS_W-1:0] r_pos;
    logic             r_wrapped;
    logic [SUM_W-1:0] r_sum;

    logic [SQ_W-1:0] r_sq;
    logic [SQ_W-1:0] r_old;
    logic            r_old_ok;

    logic signed [2*SAMPLE_W-1:0] sq_full;
    logic [SQ_W-1:0]              sq;
    logic [SQ_W-1:0]              old_sq;
    logic [SUM_W-1:0]             n_sum;

    assign sq_full = i_sample * i_sample;
    assign sq      = sq_full[SQ_W-1:0];

    // until the ring has wrapped once, the evicted entry is still zero
    assign old_sq = r_old_ok ? r_old : '0;
    assign n_sum  = r_sum - SUM_W'(old_sq) + SUM_W'(r_sq);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ring[r_pos] <= sq;
            r_old         <= r_ring[r_pos];
            r_sq          <= sq;
            r_old_ok      <= r_wrapped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_wrapped <= 1'b0;
            r_sum     <= '0;
        end else begin
            if (i_push) begin
                if (r_pos == POS_W'(WINDOW_LEN - 1)) begin
                    r_pos     <= '0;
                    r_wrapped <= 1'b1;
                end else begin
                    r_pos <= r_pos + POS_W'(1);
                end
            end
            if (i_adv) begin
                r_sum <= n_sum;
            end
        end
    end

    assign o_sum = r_sum;

endmodule

// ===== design/wpng_check.sv =====
// ----------------------------------------------------------------------------
// wpng_check
// Port-level checks of the noise gate, bound to the top level.
// ----------------------------------------------------------------------------
module wpng_check import wpng_pkg::*; (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       i_in_ready,
    input logic                       i_cfg_valid,
    input logic                       i_cfg_ready,
    input t_cfg_idx                   i_cfg_index,
    input logic [CFG_DATA_W-1:0]      i_cfg_data,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic signed [SAMPLE_W-1:0] i_out_sample,
    input logic                       i_out_open
);

    logic       r_en;
    logic       r_seen;
    logic       r_last_open;
    logic [2:0] r_inflight;
    logic       out_beat;
    logic       in_beat;

    assign out_beat = i_out_valid && i_out_ready;
    assign in_beat  = i_in_valid && i_in_ready;

    // mirror the enable bit and the flag of the last beat since any config write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en        <= 1'b0;
            r_seen      <= 1'b0;
            r_last_open <= 1'b0;
        end else if (i_cfg_valid && i_cfg_ready) begin
            r_seen <= 1'b0;
            if (i_cfg_index == CFG_GATE_ENABLE) begin
                r_en <= i_cfg_data[0];
            end
        end else if (out_beat) begin
            r_seen      <= 1'b1;
            r_last_open <= i_out_open;
        end
    end

    // count beats taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else if (in_beat && !out_beat) begin
            r_inflight <= r_inflight + 3'd1;
        end else if (out_beat && !in_beat) begin
            r_inflight <= r_inflight - 3'd1;
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_out_sample) && $stable(i_out_open))
        else $error("output beat changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input not ready while output stage is empty");

    a_frozen_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_beat && !r_en && r_seen |-> i_out_open == r_last_open)
        else $error("gate flag moved while gate disabled");

    a_inflight_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= 3'd4)
        else $error("more beats in flight than pipe stages");

endmodule

bind windowed_power_noise_gate wpng_check u_wpng_check (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in.valid),
    .i_in_ready   (i_in.ready),
    .i_cfg_valid  (i_cfg.valid),
    .i_cfg_ready  (i_cfg.ready),
    .i_cfg_index  (i_cfg.index),
    .i_cfg_data   (i_cfg.data),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_sample (o_out.sample_out),
    .i_out_open   (o_out.gate_is_open)
);
